[rtl/lrc_pkg.sv]
// Shared types and constants for the label access rule checker.
`default_nettype none

package lrc_pkg;

    // Command codes carried by the input word.
    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // Status codes of the result word.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DENY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Ordered check steps reported as the deciding step.
    localparam logic [2:0] STEP_STAR_SUBJ  = 3'd1;
    localparam logic [2:0] STEP_HAT_SUBJ   = 3'd2;
    localparam logic [2:0] STEP_FLOOR_OBJ  = 3'd3;
    localparam logic [2:0] STEP_STAR_OBJ   = 3'd4;
    localparam logic [2:0] STEP_SAME_LABEL = 3'd5;
    localparam logic [2:0] STEP_RULE       = 3'd6;
    localparam logic [2:0] STEP_NO_RULE    = 3'd7;

    // Rights encoding: bit2 read, bit1 write, bit0 execute.
    localparam int         RIGHT_WRITE_BIT = 1;
    localparam logic [2:0] ACC_WRITE       = 3'b010;

    // Width of the label fields on the ports.
    localparam int LABEL_PORT_W = 16;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_STAR  = 2'd0;
    localparam logic [1:0] REG_HAT   = 2'd1;
    localparam logic [1:0] REG_FLOOR = 2'd2;
    localparam logic [1:0] REG_ADMIN = 2'd3;

    // Table update commands broadcast to every cell.
    typedef struct packed {
        logic       shift;   // insert a new rule at cell 0, all rules move one cell on
        logic       upd;     // replace the rights of the cell whose rule key matched
        logic [2:0] flags;   // new rights
    } t_cell_ctrl;

    // Match results accumulated along the row of cells.
    typedef struct packed {
        logic       auth_hit;     // a rule matched the check key
        logic [2:0] auth_rights;  // rights of that rule
        logic       rule_hit;     // a rule matched the subject and object of an add
    } t_chain;

endpackage

`default_nettype wire

[rtl/lrc_cell.sv]
// One rule cell: holds a subject, object and rights entry and its match flags.
`default_nettype none

module lrc_cell
    import lrc_pkg::*;
#(
    parameter int LW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire logic          i_active,
    input  wire logic [LW-1:0] i_auth_subj,
    input  wire logic [LW-1:0] i_auth_obj,
    input  wire logic [LW-1:0] i_rule_subj,
    input  wire logic [LW-1:0] i_rule_obj,
    input  wire t_cell_ctrl    i_ctrl,
    input  wire logic [LW-1:0] i_left_subj,
    input  wire logic [LW-1:0] i_left_obj,
    input  wire logic [2:0]    i_left_rights,
    output logic [LW-1:0]      o_subj,
    output logic [LW-1:0]      o_obj,
    output logic [2:0]         o_rights,
    input  wire t_chain        i_chain,
    output t_chain             o_chain
);

    logic [LW-1:0] r_subj;
    logic [LW-1:0] r_obj;
    logic [2:0]    r_rights;
    logic          r_auth_hit;
    logic          r_rule_hit;

    // Rule entry: takes the left neighbor's rule on an insert, new rights on an update.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_subj   <= i_left_subj;
            r_obj    <= i_left_obj;
            r_rights <= i_left_rights;
        end else if (i_ctrl.upd && r_rule_hit) begin
            r_rights <= i_ctrl.flags;
        end
    end

    // Match flags are registered when an input word is taken in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auth_hit <= 1'b0;
            r_rule_hit <= 1'b0;
        end else if (i_load) begin
            r_auth_hit <= i_active && (r_subj == i_auth_subj) && (r_obj == i_auth_obj);
            r_rule_hit <= i_active && (r_subj == i_rule_subj) && (r_obj == i_rule_obj);
        end
    end

    assign o_subj   = r_subj;
    assign o_obj    = r_obj;
    assign o_rights = r_rights;

    // Subject and object pairs are unique in the table, so an OR gives the match.
    always_comb begin
        o_chain.auth_hit    = i_chain.auth_hit | r_auth_hit;
        o_chain.auth_rights = i_chain.auth_rights | (r_auth_hit ? r_rights : 3'b000);
        o_chain.rule_hit    = i_chain.rule_hit | r_rule_hit;
    end

endmodule

`default_nettype wire

[rtl/label_access_rule_checker.sv]
// Label access rule checker: top level with control, label registers and the rule cell row.
//
// Usage: the input channel (i_in_valid / o_in_stall) carries one command word: a check
// of a subject, object and requested rights, an add or update of a rule, or a flush of
// all rules. Add and flush are first checked as a write by the caller label to the
// admin label. Each word gives one result word (status, deciding step) on the output
// channel (o_out_valid / i_out_stall). The label registers are written through the
// configuration channel (i_cfg_valid / o_cfg_ready), which is always ready.
// Flow: a taken word is captured and the control moves from S_IDLE to S_RES. The cells
// register their compare against the new key when the word is taken, and the decision
// and table update follow at the commit in S_RES, which waits until the output register
// is free; no new word is taken until the previous one has been committed.
// Reset empties the rule table (the rule count goes to zero, no clearing pass) and
// loads the label registers with star 1, hat 2, floor 3 and admin 4.
// When the receiver stalls, the result holds in the output register; one more word
// can be taken, and its decision waits until the output register is free.
`default_nettype none

module label_access_rule_checker
    import lrc_pkg::*;
#(
    parameter int MAX_RULES  = 32,
    parameter int LABEL_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_subject_label,
    input  wire logic [15:0] i_object_label,
    input  wire logic [2:0]  i_access_request,
    input  wire logic [2:0]  i_rule_flags,
    input  wire logic [15:0] i_caller_label,
    // Output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [2:0]       o_deciding_step,
    // Configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int LW = (LABEL_BITS < LABEL_PORT_W) ? LABEL_BITS : LABEL_PORT_W;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_RULES);

    typedef enum logic {
        S_IDLE,
        S_RES
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [2:0]    r_step;

    logic [LW-1:0] r_star;
    logic [LW-1:0] r_hat;
    logic [LW-1:0] r_floor;
    logic [LW-1:0] r_admin;

    // Word held while the decision is made.
    logic [1:0]    r_cmd;
    logic [LW-1:0] r_subj;
    logic [LW-1:0] r_obj;
    logic [2:0]    r_flags;
    logic [LW-1:0] r_key_s;
    logic [LW-1:0] r_key_o;
    logic [2:0]    r_key_r;

    logic          in_accept;
    logic          commit;
    logic [LW-1:0] n_key_s;
    logic [LW-1:0] n_key_o;
    logic [2:0]    n_key_r;
    logic [LW-1:0] in_subj;
    logic [LW-1:0] in_obj;

    logic          d_deny;
    logic [2:0]    d_step;
    logic [1:0]    n_status;
    logic [2:0]    n_step;
    logic          do_flush;
    logic          do_append;
    logic          do_update;

    t_cell_ctrl    cell_ctrl;
    logic [LW-1:0] w_subj   [0:MAX_RULES];
    logic [LW-1:0] w_obj    [0:MAX_RULES];
    logic [2:0]    w_rights [0:MAX_RULES];
    t_chain        w_chain  [0:MAX_RULES];
    t_chain        hit;

    // Handshakes.
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign commit      = (r_state == S_RES) && (!r_out_valid || !i_out_stall);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_deciding_step = r_step;

    // Key of the ordered check: the word's own labels, or caller against admin.
    assign in_subj = i_subject_label[LW-1:0];
    assign in_obj  = i_object_label[LW-1:0];
    always_comb begin
        if (i_command == CMD_CHECK) begin
            n_key_s = in_subj;
            n_key_o = in_obj;
            n_key_r = i_access_request;
        end else begin
            n_key_s = i_caller_label[LW-1:0];
            n_key_o = r_admin;
            n_key_r = ACC_WRITE;
        end
    end

    // Label registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star  <= LW'(1);
            r_hat   <= LW'(2);
            r_floor <= LW'(3);
            r_admin <= LW'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_STAR:  r_star  <= i_cfg_data[LW-1:0];
                REG_HAT:   r_hat   <= i_cfg_data[LW-1:0];
                REG_FLOOR: r_floor <= i_cfg_data[LW-1:0];
                REG_ADMIN: r_admin <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Capture of the accepted word.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= i_command;
            r_subj  <= in_subj;
            r_obj   <= in_obj;
            r_flags <= i_rule_flags;
            r_key_s <= n_key_s;
            r_key_o <= n_key_o;
            r_key_r <= n_key_r;
        end
    end

    // Row of rule cells; cell 0 receives a new rule, valid cells sit below the count.
    assign w_subj[0]   = r_subj;
    assign w_obj[0]    = r_obj;
    assign w_rights[0] = r_flags;
    assign w_chain[0]  = '0;

    for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
        lrc_cell #(
            .LW (LW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_load        (in_accept),
            .i_active      (CW'(g) < r_count),
            .i_auth_subj   (n_key_s),
            .i_auth_obj    (n_key_o),
            .i_rule_subj   (in_subj),
            .i_rule_obj    (in_obj),
            .i_ctrl        (cell_ctrl),
            .i_left_subj   (w_subj[g]),
            .i_left_obj    (w_obj[g]),
            .i_left_rights (w_rights[g]),
            .o_subj        (w_subj[g+1]),
            .o_obj         (w_obj[g+1]),
            .o_rights      (w_rights[g+1]),
            .i_chain       (w_chain[g]),
            .o_chain       (w_chain[g+1])
        );
    end

    assign hit = w_chain[MAX_RULES];

    // Ordered check steps on the held key.
    always_comb begin
        if (r_key_s == r_star) begin
            d_deny = 1'b1;
            d_step = STEP_STAR_SUBJ;
        end else if (r_key_s == r_hat && !r_key_r[RIGHT_WRITE_BIT]) begin
            d_deny = 1'b0;
            d_step = STEP_HAT_SUBJ;
        end else if (r_key_o == r_floor && !r_key_r[RIGHT_WRITE_BIT]) begin
            d_deny = 1'b0;
            d_step = STEP_FLOOR_OBJ;
        end else if (r_key_o == r_star) begin
            d_deny = 1'b0;
            d_step = STEP_STAR_OBJ;
        end else if (r_key_s == r_key_o) begin
            d_deny = 1'b0;
            d_step = STEP_SAME_LABEL;
        end else if (hit.auth_hit) begin
            d_deny = |(~hit.auth_rights & r_key_r);
            d_step = STEP_RULE;
        end else begin
            d_deny = 1'b1;
            d_step = STEP_NO_RULE;
        end
    end

    // Command outcome and table actions.
    always_comb begin
        n_status  = ST_DENY;
        n_step    = STEP_NO_RULE;
        do_flush  = 1'b0;
        do_append = 1'b0;
        do_update = 1'b0;
        case (r_cmd)
            CMD_CHECK: begin
                n_status = d_deny ? ST_DENY : ST_OK;
                n_step   = d_step;
            end
            CMD_ADD: begin
                n_status = d_deny ? ST_DENY : ST_OK;
                n_step   = d_step;
                if (!d_deny) begin
                    if (hit.rule_hit) begin
                        do_update = 1'b1;
                    end else if (r_count == COUNT_FULL) begin
                        n_status = ST_FULL;
                    end else begin
                        do_append = 1'b1;
                    end
                end
            end
            CMD_FLUSH: begin
                n_status = d_deny ? ST_DENY : ST_OK;
                n_step   = d_step;
                do_flush = !d_deny;
            end
            default: ;
        endcase
    end

    assign cell_ctrl.shift = commit && do_append;
    assign cell_ctrl.upd   = commit && do_update;
    assign cell_ctrl.flags = r_flags;

    // Control state, rule count and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            r_step      <= STEP_NO_RULE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (commit) begin
                        r_status    <= n_status;
                        r_step      <= n_step;
                        r_state     <= S_IDLE;
                        if (do_flush) begin
                            r_count <= '0;
                        end else if (do_append) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // The output register fills at a commit and empties when its word is taken.
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The rule count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("rule count above table size");

    // A full-table answer leaves the count at the table size.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && n_status == ST_FULL) |=> (r_count == COUNT_FULL))
        else $error("full status with room in the table");

    // An append grows the table by exactly one rule.
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && do_append) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the rule count");

    // A denied word leaves the table size alone.
    a_deny_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && n_status == ST_DENY) |=> $stable(r_count))
        else $error("denied word changed the rule table");

endmodule

`default_nettype wire

[bench/lrc_access_monitor.sv]
// Monitor that predicts every result word of the label access rule checker and compares it.
`timescale 1ns / 1ps

module lrc_access_monitor
    import lrc_pkg::*;
#(
    parameter int MAX_RULES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_subject_label,
    input  wire logic [15:0] i_object_label,
    input  wire logic [2:0]  i_access_request,
    input  wire logic [2:0]  i_rule_flags,
    input  wire logic [15:0] i_caller_label,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_status,
    input  wire logic [2:0]  i_deciding_step,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_mismatch_count,
    output int               o_verdicts_pending
);

    // Label register values after reset.
    localparam logic [15:0] STAR_AT_RESET  = 16'd1;
    localparam logic [15:0] HAT_AT_RESET   = 16'd2;
    localparam logic [15:0] FLOOR_AT_RESET = 16'd3;
    localparam logic [15:0] ADMIN_AT_RESET = 16'd4;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] step;
    } verdict_t;

    // Shadow copy of the label registers and of the rule table.
    logic [15:0] star_lbl;
    logic [15:0] hat_lbl;
    logic [15:0] floor_lbl;
    logic [15:0] admin_lbl;
    logic [15:0] rule_subj [MAX_RULES];
    logic [15:0] rule_obj  [MAX_RULES];
    logic [2:0]  rule_acc  [MAX_RULES];
    int          rule_total;

    verdict_t expected_verdicts [$];

    // Ordered access decision; the first step that decides wins.
    function automatic verdict_t decide_access(input logic [15:0] subj, input logic [15:0] obj,
                                               input logic [2:0] req);
        verdict_t v;
        logic     write_req;
        logic     hit;
        v.status  = ST_DENY;
        v.step    = STEP_NO_RULE;
        write_req = req[RIGHT_WRITE_BIT];
        hit       = 1'b0;
        if (subj == star_lbl) begin
            v.step = STEP_STAR_SUBJ;
        end else if (subj == hat_lbl && !write_req) begin
            v.status = ST_OK;
            v.step   = STEP_HAT_SUBJ;
        end else if (obj == floor_lbl && !write_req) begin
            v.status = ST_OK;
            v.step   = STEP_FLOOR_OBJ;
        end else if (obj == star_lbl) begin
            v.status = ST_OK;
            v.step   = STEP_STAR_OBJ;
        end else if (subj == obj) begin
            v.status = ST_OK;
            v.step   = STEP_SAME_LABEL;
        end else begin
            // Only the oldest matching rule counts.
            for (int i = 0; i < MAX_RULES; i++) begin
                if (!hit && i < rule_total && rule_subj[i] == subj && rule_obj[i] == obj) begin
                    hit      = 1'b1;
                    v.step   = STEP_RULE;
                    v.status = ((~rule_acc[i] & req) != 3'b000) ? ST_DENY : ST_OK;
                end
            end
        end
        return v;
    endfunction

    // Applies one accepted command word to the shadow table and returns its verdict.
    function automatic verdict_t apply_word(input logic [1:0] cmd, input logic [15:0] subj,
                                            input logic [15:0] obj, input logic [2:0] req,
                                            input logic [2:0] flags, input logic [15:0] caller);
        verdict_t v;
        logic     hit;
        v.status = ST_DENY;
        v.step   = STEP_NO_RULE;
        hit      = 1'b0;
        if (cmd == CMD_CHECK) begin
            v = decide_access(subj, obj, req);
        end else if (cmd == CMD_ADD || cmd == CMD_FLUSH) begin
            // Table changes need write access from the caller to the admin label.
            v = decide_access(caller, admin_lbl, ACC_WRITE);
            if (v.status == ST_OK) begin
                if (cmd == CMD_FLUSH) begin
                    rule_total = 0;
                end else begin
                    for (int i = 0; i < MAX_RULES; i++) begin
                        if (!hit && i < rule_total && rule_subj[i] == subj &&
                            rule_obj[i] == obj) begin
                            rule_acc[i] = flags;
                            hit         = 1'b1;
                        end
                    end
                    if (!hit) begin
                        if (rule_total >= MAX_RULES) begin
                            v.status = ST_FULL;
                        end else begin
                            rule_subj[rule_total] = subj;
                            rule_obj[rule_total]  = obj;
                            rule_acc[rule_total]  = flags;
                            rule_total++;
                        end
                    end
                end
            end
        end
        return v;
    endfunction

    // Watch all three channels at the rising edge.
    always @(posedge i_clk) begin : watch
        verdict_t got;
        verdict_t want;
        if (!i_rst_n) begin
            star_lbl         = STAR_AT_RESET;
            hat_lbl          = HAT_AT_RESET;
            floor_lbl        = FLOOR_AT_RESET;
            admin_lbl        = ADMIN_AT_RESET;
            rule_total       = 0;
            o_mismatch_count = 0;
            expected_verdicts.delete();
        end else begin
            // Compare a delivered result word with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                got.status = i_status;
                got.step   = i_deciding_step;
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result word, status %0d step %0d",
                             $realtime, got.status, got.step);
                    o_mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $realtime, want.status, got.status);
                    end
                    if (got.step != want.step) begin
                        $display("%0t: deciding step mismatch, expected %0d, actual %0d",
                                 $realtime, want.step, got.step);
                    end
                    if (got != want) begin
                        o_mismatch_count++;
                    end
                end
            end

            // Track label register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_STAR:  star_lbl  = i_cfg_data;
                    REG_HAT:   hat_lbl   = i_cfg_data;
                    REG_FLOOR: floor_lbl = i_cfg_data;
                    REG_ADMIN: admin_lbl = i_cfg_data;
                    default: ;
                endcase
            end

            // Predict the result of each accepted command word.
            if (i_in_valid && !i_in_stall) begin
                expected_verdicts.push_back(apply_word(i_command, i_subject_label,
                                                       i_object_label, i_access_request,
                                                       i_rule_flags, i_caller_label));
            end
        end
        o_verdicts_pending = expected_verdicts.size();
    end

endmodule

[bench/label_access_rule_checker_tb.sv]
// Testbench top for the label access rule checker: stimulus, flow control and final verdict.
`timescale 1ns / 1ps

module label_access_rule_checker_tb;
    import lrc_pkg::*;

    // The fourth command code is unused by the block.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 60;
    localparam int         FILL_WORDS  = 36;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [15:0] i_subject_label;
    logic [15:0] i_object_label;
    logic [2:0]  i_access_request;
    logic [2:0]  i_rule_flags;
    logic [15:0] i_caller_label;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [2:0]  o_deciding_step;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int mismatch_count;
    int verdicts_pending;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    // Current label register values, used to aim the stimulus.
    logic [15:0] star_now;
    logic [15:0] hat_now;
    logic [15:0] floor_now;
    logic [15:0] admin_now;

    label_access_rule_checker uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_subject_label  (i_subject_label),
        .i_object_label   (i_object_label),
        .i_access_request (i_access_request),
        .i_rule_flags     (i_rule_flags),
        .i_caller_label   (i_caller_label),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_deciding_step  (o_deciding_step),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    lrc_access_monitor access_monitor (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_subject_label    (i_subject_label),
        .i_object_label     (i_object_label),
        .i_access_request   (i_access_request),
        .i_rule_flags       (i_rule_flags),
        .i_caller_label     (i_caller_label),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_status           (o_status),
        .i_deciding_step    (o_deciding_step),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_mismatch_count   (mismatch_count),
        .o_verdicts_pending (verdicts_pending)
    );

    // 50 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result receiver: random stalls, plus long hold-offs on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Offers one command word, with random idle cycles ahead of it, and waits until taken.
    task automatic send_word(input logic [1:0] cmd, input logic [15:0] subj,
                             input logic [15:0] obj, input logic [2:0] req,
                             input logic [2:0] flags, input logic [15:0] caller);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_command        = cmd;
        i_subject_label  = subj;
        i_object_label   = obj;
        i_access_request = req;
        i_rule_flags     = flags;
        i_caller_label   = caller;
        i_in_valid       = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic program_labels(input logic [15:0] star, input logic [15:0] hat,
                                  input logic [15:0] floor, input logic [15:0] admin);
        write_reg(REG_STAR, star);
        write_reg(REG_HAT, hat);
        write_reg(REG_FLOOR, floor);
        write_reg(REG_ADMIN, admin);
        star_now  = star;
        hat_now   = hat;
        floor_now = floor;
        admin_now = admin;
    endtask

    // Drops valid and waits until every predicted result has been delivered.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (verdicts_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Labels come mostly from a small pool so that rules collide and match.
    function automatic logic [15:0] pick_label();
        logic [15:0] lbl;
        lbl = 16'($urandom);
        case ($urandom_range(0, 9))
            0: lbl = star_now;
            1: lbl = hat_now;
            2: lbl = floor_now;
            3: lbl = admin_now;
            8: ;
            9: lbl = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: lbl = 16'h0040 + lbl[2:0];
        endcase
        return lbl;
    endfunction

    task automatic send_random_word();
        int          pick;
        logic [1:0]  cmd;
        logic [15:0] caller;
        logic [2:0]  req;
        logic [2:0]  flags;
        pick   = $urandom_range(0, 99);
        req    = 3'($urandom_range(0, 7));
        flags  = 3'($urandom_range(0, 7));
        caller = ($urandom_range(0, 99) < 75) ? admin_now : pick_label();
        if (pick < 55) begin
            cmd = CMD_CHECK;
        end else if (pick < 93) begin
            cmd = CMD_ADD;
        end else if (pick < 96) begin
            cmd = CMD_FLUSH;
        end else begin
            cmd = CMD_UNUSED;
        end
        send_word(cmd, pick_label(), pick_label(), req, flags, caller);
    endtask

    // Random traffic with a burst of distinct adds in the middle to run the table full.
    task automatic random_phase(input int count);
        logic [15:0] obj;
        logic [2:0]  flags;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                for (int k = 0; k < FILL_WORDS; k++) begin
                    obj   = 16'($urandom);
                    flags = 3'($urandom_range(0, 7));
                    send_word(CMD_ADD, pick_label(), obj, 3'b000, flags, admin_now);
                end
            end
            send_random_word();
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_command        = CMD_CHECK;
        i_subject_label  = 16'h0000;
        i_object_label   = 16'h0000;
        i_access_request = 3'b000;
        i_rule_flags     = 3'b000;
        i_caller_label   = 16'h0000;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = REG_STAR;
        i_cfg_data       = 16'h0000;
        star_now         = 16'd1;
        hat_now          = 16'd2;
        floor_now        = 16'd3;
        admin_now        = 16'd4;
        send_idle_pct    = 31;
        recv_idle_pct    = 71;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words on the reset labels: star 1, hat 2, floor 3, admin 4.
        send_word(CMD_CHECK, 16'd1, 16'd5, 3'b111, 3'b000, 16'd0);   // star subject
        send_word(CMD_CHECK, 16'd2, 16'd5, 3'b101, 3'b000, 16'd0);   // hat subject reads
        send_word(CMD_CHECK, 16'd2, 16'd5, 3'b010, 3'b000, 16'd0);   // hat subject writes
        send_word(CMD_CHECK, 16'd6, 16'd3, 3'b100, 3'b000, 16'd0);   // floor object reads
        send_word(CMD_CHECK, 16'd6, 16'd3, 3'b110, 3'b000, 16'd0);   // floor object writes
        send_word(CMD_CHECK, 16'd6, 16'd1, 3'b111, 3'b000, 16'd0);   // star object
        send_word(CMD_CHECK, 16'd9, 16'd9, 3'b111, 3'b000, 16'd0);   // same labels
        send_word(CMD_ADD, 16'd10, 16'd11, 3'b000, 3'b101, 16'd1);   // star caller denied
        send_word(CMD_ADD, 16'd10, 16'd11, 3'b000, 3'b101, 16'd9);   // unknown caller denied
        send_word(CMD_ADD, 16'd10, 16'd11, 3'b000, 3'b101, 16'd4);   // admin appends
        send_word(CMD_CHECK, 16'd10, 16'd11, 3'b100, 3'b000, 16'd0);
        send_word(CMD_CHECK, 16'd10, 16'd11, 3'b010, 3'b000, 16'd0);
        send_word(CMD_ADD, 16'd10, 16'd11, 3'b000, 3'b010, 16'd4);   // update in place
        send_word(CMD_CHECK, 16'd10, 16'd11, 3'b010, 3'b000, 16'd0);
        send_word(CMD_ADD, 16'd20, 16'd4, 3'b000, 3'b010, 16'd4);    // grant label 20 admin write
        send_word(CMD_FLUSH, 16'd0, 16'd0, 3'b000, 3'b000, 16'd20);  // flush through a rule
        send_word(CMD_CHECK, 16'd10, 16'd11, 3'b100, 3'b000, 16'd0); // table is empty
        send_word(CMD_FLUSH, 16'd0, 16'd0, 3'b000, 3'b000, 16'd2);   // hat caller cannot write
        send_word(CMD_UNUSED, 16'd10, 16'd11, 3'b111, 3'b111, 16'd4);
        send_word(CMD_ADD, 16'hFFFF, 16'h0000, 3'b000, 3'b111, 16'd4);
        send_word(CMD_CHECK, 16'hFFFF, 16'h0000, 3'b111, 3'b000, 16'hFFFF);
        send_word(CMD_ADD, 16'hFFFF, 16'h0000, 3'b000, 3'b000, 16'd4);
        send_word(CMD_CHECK, 16'hFFFF, 16'h0000, 3'b001, 3'b000, 16'd0);
        send_word(CMD_CHECK, 16'h0000, 16'hFFFF, 3'b000, 3'b000, 16'd0);
        send_word(CMD_FLUSH, 16'd0, 16'd0, 3'b000, 3'b000, 16'd4);
        settle();

        // Sender idles less than the receiver.
        program_labels(16'h0000, 16'hFFFF, 16'h0010, 16'h0011);
        random_phase(150);
        settle();

        // Receiver idles less than the sender.
        send_idle_pct = 71;
        recv_idle_pct = 31;
        program_labels(16'hFFFF, 16'h0000, 16'h8000, 16'h0001);
        random_phase(150);
        settle();

        // Full rate, starting with a long receiver hold-off so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_labels(16'h0005, 16'h0006, 16'h0007, 16'h0008);
        hold_requests++;
        random_phase(150);
        settle();

        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
